/* rtl/core/assert_macros.svh */
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every rising clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/core/bapct_pkg.sv */
package bapct_pkg;

  localparam int RAW_W   = 16;
  localparam int REF_W   = 10;
  localparam int GAIN_W  = 4;
  localparam int SCALE_W = REF_W + GAIN_W;
  localparam int MV_W    = 13;
  localparam int PCT_W   = 7;
  localparam int SEG_W   = 2;
  localparam int OFF_W   = 9;
  localparam int DP_W    = 5;
  localparam int NUM_W   = 14;
  localparam int RCP_W   = 13;
  localparam int RCP_SH  = 20;
  localparam int QUO_W   = 7;
  localparam int REM_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int N_STAGES  = 7;

  localparam int ADC_BITS_DEFAULT = 12;

  localparam logic [REF_W-1:0]  RESET_REF_MV   = REF_W'(600);
  localparam logic [GAIN_W-1:0] RESET_GAIN_DIV = GAIN_W'(6);
  localparam logic [MV_W-1:0]   MV_MAX         = MV_W'(8191);

  localparam logic [MV_W-1:0] BP0_MV = MV_W'(3000);
  localparam logic [MV_W-1:0] BP1_MV = MV_W'(3400);
  localparam logic [MV_W-1:0] BP2_MV = MV_W'(3700);
  localparam logic [MV_W-1:0] BP3_MV = MV_W'(3900);
  localparam logic [MV_W-1:0] BP4_MV = MV_W'(4200);

  localparam logic [RCP_W-1:0] RCP_400 = RCP_W'((1 << RCP_SH) / 400);
  localparam logic [RCP_W-1:0] RCP_300 = RCP_W'((1 << RCP_SH) / 300);
  localparam logic [RCP_W-1:0] RCP_200 = RCP_W'((1 << RCP_SH) / 200);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REF_MV   = 2'd0,
    REG_GAIN_DIV = 2'd1
  } reg_index_t;

  function automatic logic [MV_W-1:0] seg_lo(input logic [SEG_W-1:0] seg);
    logic [MV_W-1:0] r;
    unique case (seg)
      2'd0: r = BP0_MV;
      2'd1: r = BP1_MV;
      2'd2: r = BP2_MV;
      default: r = BP3_MV;
    endcase
    return r;
  endfunction

  function automatic logic [PCT_W-1:0] seg_pct(input logic [SEG_W-1:0] seg);
    logic [PCT_W-1:0] r;
    unique case (seg)
      2'd0: r = PCT_W'(0);
      2'd1: r = PCT_W'(20);
      2'd2: r = PCT_W'(50);
      default: r = PCT_W'(80);
    endcase
    return r;
  endfunction

  function automatic logic [DP_W-1:0] seg_dp(input logic [SEG_W-1:0] seg);
    logic [DP_W-1:0] r;
    unique case (seg)
      2'd0: r = DP_W'(20);
      2'd1: r = DP_W'(30);
      2'd2: r = DP_W'(30);
      default: r = DP_W'(20);
    endcase
    return r;
  endfunction

  function automatic logic [OFF_W-1:0] seg_span(input logic [SEG_W-1:0] seg);
    logic [OFF_W-1:0] r;
    unique case (seg)
      2'd0: r = OFF_W'(400);
      2'd1: r = OFF_W'(300);
      2'd2: r = OFF_W'(200);
      default: r = OFF_W'(300);
    endcase
    return r;
  endfunction

  function automatic logic [RCP_W-1:0] seg_recip(input logic [SEG_W-1:0] seg);
    logic [RCP_W-1:0] r;
    unique case (seg)
      2'd0: r = RCP_400;
      2'd1: r = RCP_300;
      2'd2: r = RCP_200;
      default: r = RCP_300;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/battery_adc_to_percent.sv */
// battery voltage and state of charge from one adc sample
// input channel: raw_sample with sample_valid; the block drives sample_stall.
// output channel: battery_mv and charge_percent with result_valid; the
// receiver drives result_stall. a transaction completes on a clock edge with
// valid high and stall low.
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is
// the reference in mV, index 1 the gain divisor, other indexes are ignored.
// cfg_ready is always high; write only while no transaction is in flight.
// seven register stages (clamp, scale multiply, shift and saturate, segment
// pick, slope multiply, reciprocal multiply, remainder fix-up) lie between an
// input transaction and result_valid. throughput: one transaction per cycle
// unless the receiver stalls; no clearing pass after reset.
// reset (synchronous) empties the pipeline and loads 600 mV and divisor 6.
// when the receiver stalls with a result waiting, the whole pipeline holds
// and sample_stall rises in the same cycle; nothing is lost or repeated.
`include "assert_macros.svh"

module battery_adc_to_percent
  import bapct_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  logic signed [RAW_W-1:0] raw_sample,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [MV_W-1:0]      battery_mv,
  output logic [PCT_W-1:0]     charge_percent,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REF_W-1:0]     cfg_data
);

  localparam int PROD_W = ADC_BITS + SCALE_W;
  localparam logic [RAW_W:0] SAMPLE_MAX = (RAW_W + 1)'((1 << ADC_BITS) - 1);

  logic [REF_W-1:0]  ref_mv;
  logic [GAIN_W-1:0] gain_div;

  logic [N_STAGES-1:0] vld;
  logic                adv;

  logic [ADC_BITS-1:0] s1_sample;
  logic [SCALE_W-1:0]  s1_scale;
  logic [PROD_W-1:0]   s2_prod;
  logic [MV_W-1:0]     s3_mv;
  logic [MV_W-1:0]     s4_mv;
  logic [SEG_W-1:0]    s4_seg;
  logic [OFF_W-1:0]    s4_off;
  logic [MV_W-1:0]     s5_mv;
  logic [SEG_W-1:0]    s5_seg;
  logic [NUM_W-1:0]    s5_num;
  logic [MV_W-1:0]     s6_mv;
  logic [SEG_W-1:0]    s6_seg;
  logic [NUM_W-1:0]    s6_num;
  logic [QUO_W-1:0]    s6_quot;

  logic [ADC_BITS-1:0]    sample_clamp;
  logic [SCALE_W-1:0]     scale;
  logic [SCALE_W-1:0]     mv_full;
  logic [MV_W-1:0]        mv_sat;
  logic [SEG_W-1:0]       seg_next;
  logic [OFF_W-1:0]       off_next;
  logic [NUM_W+RCP_W-1:0] rcp_prod;
  logic [OFF_W-1:0]       s6_span;
  logic [REM_W-1:0]       s6_rem;
  logic [QUO_W-1:0]       quot_fix;

  assign cfg_ready    = 1'b1;
  assign adv          = !(result_valid && result_stall);
  assign sample_stall = !adv;
  assign result_valid = vld[N_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_mv   <= RESET_REF_MV;
      gain_div <= RESET_GAIN_DIV;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_REF_MV:   ref_mv   <= cfg_data;
        REG_GAIN_DIV: gain_div <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: clamp to the adc range
  always_comb begin
    if (raw_sample[RAW_W-1]) begin
      sample_clamp = '0;
    end else if ({1'b0, raw_sample} > SAMPLE_MAX) begin
      sample_clamp = SAMPLE_MAX[ADC_BITS-1:0];
    end else begin
      sample_clamp = raw_sample[ADC_BITS-1:0];
    end
  end

  assign scale = SCALE_W'(ref_mv) * SCALE_W'(gain_div);

  // stage 3: drop fraction and saturate
  assign mv_full = s2_prod[PROD_W-1:ADC_BITS];
  assign mv_sat  = (mv_full > SCALE_W'(MV_MAX)) ? MV_MAX : mv_full[MV_W-1:0];

  // stage 4: pick segment; ends clamp onto the first and last segment
  always_comb begin
    if (s3_mv <= BP0_MV) begin
      seg_next = 2'd0;
      off_next = '0;
    end else if (s3_mv <= BP1_MV) begin
      seg_next = 2'd0;
      off_next = OFF_W'(s3_mv - BP0_MV);
    end else if (s3_mv <= BP2_MV) begin
      seg_next = 2'd1;
      off_next = OFF_W'(s3_mv - BP1_MV);
    end else if (s3_mv <= BP3_MV) begin
      seg_next = 2'd2;
      off_next = OFF_W'(s3_mv - BP2_MV);
    end else if (s3_mv < BP4_MV) begin
      seg_next = 2'd3;
      off_next = OFF_W'(s3_mv - BP3_MV);
    end else begin
      seg_next = 2'd3;
      off_next = OFF_W'(BP4_MV - BP3_MV);
    end
  end

  // stage 6: quotient estimate, floor or one below
  assign rcp_prod = (NUM_W + RCP_W)'(s5_num) * (NUM_W + RCP_W)'(seg_recip(s5_seg));

  // stage 7: one-step correction
  assign s6_span  = seg_span(s6_seg);
  assign s6_rem   = REM_W'(s6_num) - REM_W'(s6_quot) * REM_W'(s6_span);
  assign quot_fix = (s6_rem >= REM_W'(s6_span)) ? s6_quot + QUO_W'(1) : s6_quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[N_STAGES-2:0], sample_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sample      <= sample_clamp;
      s1_scale       <= scale;
      s2_prod        <= PROD_W'(s1_sample) * PROD_W'(s1_scale);
      s3_mv          <= mv_sat;
      s4_mv          <= s3_mv;
      s4_seg         <= seg_next;
      s4_off         <= off_next;
      s5_mv          <= s4_mv;
      s5_seg         <= s4_seg;
      s5_num         <= NUM_W'(s4_off) * NUM_W'(seg_dp(s4_seg));
      s6_mv          <= s5_mv;
      s6_seg         <= s5_seg;
      s6_num         <= s5_num;
      s6_quot        <= rcp_prod[RCP_SH +: QUO_W];
      battery_mv     <= s6_mv;
      charge_percent <= seg_pct(s6_seg) + quot_fix;
    end
  end

  `ASSERT_IMPLIES(a_pct_range, clk, rst, result_valid, charge_percent <= PCT_W'(100), "charge_percent above 100")
  `ASSERT_IMPLIES(a_pct_low, clk, rst, result_valid && battery_mv <= BP0_MV, charge_percent == '0, "charge not zero at or below the lowest breakpoint")
  `ASSERT_IMPLIES(a_pct_high, clk, rst, result_valid && battery_mv >= BP4_MV, charge_percent == PCT_W'(100), "charge not full at or above the highest breakpoint")
  `ASSERT_IMPLIES(a_rcp_err, clk, rst, vld[N_STAGES-2], s6_rem < (REM_W'(s6_span) << 1), "reciprocal estimate off by more than one")
  `ASSERT_HOLDS(a_stall_src, clk, rst, !sample_stall || (result_valid && result_stall), "input stalled without a held result")

endmodule

/* verif/tb_battery_adc_to_percent.sv */
module tb_battery_adc_to_percent;
  import bapct_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_MAX = (1 << ADC_BITS_DEFAULT) - 1;
  localparam int KNEE_MV  [5] = '{3000, 3400, 3700, 3900, 4200};
  localparam int KNEE_PCT [5] = '{0, 20, 50, 80, 100};
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int PHASE_ITEMS = 70;

  typedef struct {
    logic signed [RAW_W-1:0] raw;
    int                      gap;
  } sample_req_t;

  typedef struct {
    logic signed [RAW_W-1:0] raw;
    logic [MV_W-1:0]         mv;
    logic [PCT_W-1:0]        pct;
  } charge_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    sample_valid = 1'b0;
  logic                    sample_stall;
  logic signed [RAW_W-1:0] raw_sample = '0;
  logic                    result_valid;
  logic                    result_stall = 1'b0;
  logic [MV_W-1:0]         battery_mv;
  logic [PCT_W-1:0]        charge_percent;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [REF_W-1:0]        cfg_data = '0;

  sample_req_t sample_q[$];
  charge_t     charge_due[$];
  sample_req_t next_req;
  charge_t     got_due;
  logic [REF_W-1:0]  cur_ref;
  logic [GAIN_W-1:0] cur_gain;
  logic sample_took = 1'b0;
  logic result_took = 1'b0;
  int   idle_mode = 0;
  int   samples_queued = 0;
  int   samples_taken = 0;
  int   errors = 0;
  int   gap_left = 0;
  bit   gap_armed = 1'b0;
  int   rx_wait = 0;

  battery_adc_to_percent #(
    .ADC_BITS(ADC_BITS_DEFAULT)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .sample_valid  (sample_valid),
    .sample_stall  (sample_stall),
    .raw_sample    (raw_sample),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .battery_mv    (battery_mv),
    .charge_percent(charge_percent),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int draw_wait(input int mode);
    case (mode)
      0: return 0;
      1: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 18)) : 0;
      default: return int'($urandom_range(0, 18));
    endcase
  endfunction

  function automatic charge_t predict_charge(input logic signed [RAW_W-1:0] raw,
                                             input logic [REF_W-1:0] rf,
                                             input logic [GAIN_W-1:0] gd);
    charge_t c;
    longint  s;
    longint  v;
    bit      hit;
    c.raw = raw;
    hit = 1'b0;
    if (raw < 0) s = 0;
    else if (raw > SAMPLE_MAX) s = SAMPLE_MAX;
    else s = longint'(raw);
    v = (s * longint'(rf) * longint'(gd)) >>> ADC_BITS_DEFAULT;
    if (v > 8191) v = 8191;
    c.mv = MV_W'(v);
    c.pct = '0;
    if (v >= KNEE_MV[4]) begin
      c.pct = PCT_W'(KNEE_PCT[4]);
    end else if (v > KNEE_MV[0]) begin
      for (int k = 0; k < 4; k++) begin
        if (!hit && v >= KNEE_MV[k] && v <= KNEE_MV[k+1]) begin
          c.pct = PCT_W'(KNEE_PCT[k] + (KNEE_PCT[k+1] - KNEE_PCT[k]) * (v - KNEE_MV[k])
                         / (KNEE_MV[k+1] - KNEE_MV[k]));
          hit = 1'b1;
        end
      end
    end
    return c;
  endfunction

  // aim about half the samples at the interesting voltage band for the current scale
  function automatic logic signed [RAW_W-1:0] pick_sample(input int unsigned rf,
                                                         input int unsigned gd);
    int unsigned sel;
    longint      s;
    sel = $urandom_range(0, 9);
    if (sel < 5 && rf * gd != 0) begin
      s = (longint'($urandom_range(2900, 4300)) << ADC_BITS_DEFAULT) / longint'(rf * gd)
          + longint'($urandom_range(0, 2)) - 1;
      if (s < 0) s = 0;
      if (s > 32767) s = 32767;
    end else if (sel < 7) begin
      s = $urandom_range(0, SAMPLE_MAX);
    end else if (sel == 7) begin
      s = -longint'($urandom_range(1, 32768));
    end else if (sel == 8) begin
      s = $urandom_range(SAMPLE_MAX + 1, 32767);
    end else begin
      s = $urandom_range(0, 65535);
    end
    return RAW_W'(s);
  endfunction

  // sample driver
  always @(negedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
      gap_armed = 1'b0;
    end else if (!(sample_valid && !sample_took)) begin
      if (!gap_armed && sample_q.size() != 0) begin
        gap_left = sample_q[0].gap;
        gap_armed = 1'b1;
      end
      if (!gap_armed) begin
        sample_valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left = gap_left - 1;
        sample_valid <= 1'b0;
      end else begin
        next_req = sample_q.pop_front();
        gap_armed = 1'b0;
        sample_valid <= 1'b1;
        raw_sample <= next_req.raw;
      end
    end
  end

  // result receiver back-pressure
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (result_took) rx_wait = draw_wait(idle_mode);
      result_stall <= (rx_wait != 0);
      if (rx_wait != 0 && result_valid) rx_wait = rx_wait - 1;
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    if (rst) begin
      cur_ref <= RESET_REF_MV;
      cur_gain <= RESET_GAIN_DIV;
      sample_took <= 1'b0;
      result_took <= 1'b0;
    end else begin
      sample_took <= sample_valid && !sample_stall;
      result_took <= result_valid && !result_stall;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_REF_MV) cur_ref <= cfg_data;
        else if (cfg_index == REG_GAIN_DIV) cur_gain <= cfg_data[GAIN_W-1:0];
      end
      if (sample_valid && !sample_stall) begin
        charge_due.push_back(predict_charge(raw_sample, cur_ref, cur_gain));
        samples_taken++;
      end
      if (result_valid && !result_stall) begin
        if (charge_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result transaction: mv %0d pct %0d",
                     battery_mv, charge_percent);
        end else begin
          got_due = charge_due.pop_front();
          if (battery_mv !== got_due.mv || charge_percent !== got_due.pct) begin
            errors++;
            if (errors <= 10)
              $display("mismatch for raw %0d: expected mv %0d pct %0d, got mv %0d pct %0d",
                       got_due.raw, got_due.mv, got_due.pct, battery_mv, charge_percent);
          end
        end
      end
    end
  end

  task automatic queue_sample(input logic signed [RAW_W-1:0] raw);
    sample_req_t r;
    r.raw = raw;
    r.gap = draw_wait(idle_mode);
    sample_q.push_back(r);
    samples_queued++;
  endtask

  task automatic settle();
    while (samples_taken != samples_queued || charge_due.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [REF_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // gain data carries random upper bits, only the low nibble lands
  task automatic set_config(input int unsigned rf, input int unsigned gd);
    cfg_write(REG_SPARE_A, REF_W'($urandom));
    cfg_write(REG_REF_MV, REF_W'(rf));
    cfg_write(REG_GAIN_DIV, {6'($urandom), 4'(gd)});
    cfg_write(REG_SPARE_B, REF_W'($urandom));
    @(posedge clk);
  endtask

  initial begin
    int unsigned rf;
    int unsigned gd;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset scale: clamping and bit extremes
    queue_sample(-16'sd32768);
    queue_sample(-16'sd1);
    queue_sample(16'sd0);
    queue_sample(16'sd1);
    queue_sample(16'sd4095);
    queue_sample(16'sd4096);
    queue_sample(16'sd32767);
    queue_sample(16'sh5555);
    queue_sample(16'shAAAA);
    settle();

    // unit scale: millivolts equal the sample, breakpoints hit exactly
    set_config(512, 8);
    queue_sample(16'sd2999);
    queue_sample(16'sd3000);
    queue_sample(16'sd3001);
    queue_sample(16'sd3399);
    queue_sample(16'sd3400);
    queue_sample(16'sd3700);
    queue_sample(16'sd3900);
    queue_sample(16'sd4095);
    settle();

    set_config(1000, 7);
    queue_sample(16'sd2457);
    queue_sample(16'sd2458);
    settle();

    // zero reference, then saturation above full scale
    set_config(0, 6);
    queue_sample(16'sd4095);
    settle();
    set_config(1023, 15);
    queue_sample(16'sd4095);
    queue_sample(16'sd2500);
    settle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin rf = 1000; gd = 8; end
        1: begin rf = 600;  gd = 6; end
        2: begin rf = 1;    gd = 1; end
        3: begin rf = 1023; gd = 15; end
        5: begin rf = 750;  gd = 0; end
        7: begin rf = 512;  gd = 8; end
        default: begin rf = $urandom_range(1, 1000); gd = $urandom_range(1, 8); end
      endcase
      idle_mode = p % 3;
      set_config(rf, gd);
      for (int i = 0; i < PHASE_ITEMS; i++) queue_sample(pick_sample(rf, gd));
      settle();
    end

    if (errors == 0 && charge_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
